>>> src/tq_pkg.sv
// Shared types and constants for the tiered top-k priority queue.
// No dependencies; the cells, the top module and the bench import this package.
package tq_pkg;

  localparam int GOOD_DEPTH = 16;
  localparam int RUN_DEPTH  = 8;
  localparam int OVF_DEPTH  = 256;
  localparam int GW = $clog2(GOOD_DEPTH);
  localparam int RW = $clog2(RUN_DEPTH);
  localparam int OW = $clog2(OVF_DEPTH);

  localparam logic CFG_GOOD_SIZE   = 1'b0;
  localparam logic CFG_RUNNER_SIZE = 1'b1;
  localparam logic KIND_ENQ = 1'b0;

  typedef struct packed {
    logic [31:0]        key;
    logic [31:0]        tag;
    logic signed [31:0] score;
  } entry_t;

  typedef enum logic [1:0] {G_HOLD, G_APPEND, G_REMOVE, G_REMAPP} good_cmd_t;
  typedef enum logic [1:0] {R_HOLD, R_INSERT, R_SHIFT} run_cmd_t;

  typedef struct packed {
    good_cmd_t     cmd;
    logic [GW-1:0] idx;
    logic [GW:0]   cnt;
    entry_t        ent;
  } good_ctl_t;

  typedef struct packed {
    run_cmd_t      cmd;
    logic [RW:0]   cnt;
    entry_t        ent;
  } run_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ENQ, S_DEQ, S_SCAN, S_RADMIT, S_RINS,
    S_REF_RD, S_REF_USE, S_REF_NEXT, S_DONE
  } state_t;

  typedef enum logic [2:0] {P_THR, P_EVICT, P_MAX, P_REFMIN, P_REFTHR} purp_t;

endpackage

>>> src/tq_in_if.sv
// Input channel: one beat carries an enqueue or dequeue request.
// Depends on nothing.
interface tq_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [31:0]        entry_key;
  logic [31:0]        entry_tag;
  logic signed [31:0] entry_score;
  modport source(output valid, kind, entry_key, entry_tag, entry_score, input ready);
  modport sink(input valid, kind, entry_key, entry_tag, entry_score, output ready);
endinterface

>>> src/tq_out_if.sv
// Result channel: one beat per request.
// Depends on nothing.
interface tq_out_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic [31:0]        out_key;
  logic [31:0]        out_tag;
  logic signed [31:0] out_score;
  logic               dropped;
  logic [8:0]         total_count;
  modport source(output valid, found, out_key, out_tag, out_score, dropped, total_count,
                 input ready);
  modport sink(input valid, found, out_key, out_tag, out_score, dropped, total_count,
               output ready);
endinterface

>>> src/tq_good_cell.sv
// One slot of the arrival-ordered good tier; shifts toward slot 0 on removal.
// Depends on tq_pkg.
module tq_good_cell import tq_pkg::*; (
  input  logic          clk,
  input  good_ctl_t     ctl,
  input  logic [GW-1:0] pos,
  input  entry_t        next_i,
  output entry_t        ent_o
);
  entry_t ent_r, ent_nxt;
  logic   at_tail, at_last, past_idx;

  always_comb begin
    at_tail  = ({1'b0, pos} == ctl.cnt);
    at_last  = ({1'b0, pos} == ctl.cnt - 1'b1);
    past_idx = (pos >= ctl.idx);
    ent_nxt  = ent_r;
    case (ctl.cmd)
      G_APPEND: if (at_tail) ent_nxt = ctl.ent;
      G_REMOVE: if (past_idx) ent_nxt = next_i;
      G_REMAPP: begin
        if (at_last) ent_nxt = ctl.ent;
        else if (past_idx) ent_nxt = next_i;
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent_o = ent_r;
endmodule

>>> src/tq_run_cell.sv
// One slot of the ascending runner-up tier; parallel sorted insert, shift on eviction.
// Depends on tq_pkg.
module tq_run_cell import tq_pkg::*; (
  input  logic          clk,
  input  run_ctl_t      ctl,
  input  logic [RW-1:0] pos,
  input  entry_t        prev_i,
  input  logic          prev_lt_i,
  input  entry_t        next_i,
  output entry_t        ent_o,
  output logic          lt_o
);
  entry_t ent_r, ent_nxt;

  assign lt_o = ({1'b0, pos} < ctl.cnt) && (ent_r.score < ctl.ent.score);

  always_comb begin
    ent_nxt = ent_r;
    case (ctl.cmd)
      R_INSERT: begin
        if (!lt_o) begin
          if (pos == '0 || prev_lt_i) ent_nxt = ctl.ent;
          else ent_nxt = prev_i;
        end
      end
      R_SHIFT: ent_nxt = next_i;
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent_o = ent_r;
endmodule

>>> src/tiered_topk_priority_queue.sv
// Tiered top-k priority queue. One request is in flight at a time; the result register
// frees the input side, so the next request is taken in the cycle its result leaves.
// An enqueue into a good tier with room goes from the enqueue state to the done state; one
// sent to runner-up admission adds the admit state, plus a reinsert state when that tier
// evicts its minimum to overflow. The enqueue that fills the good tier adds one walk of the
// good tier (one slot a cycle over its single read port); one that displaces a good entry
// sends the displaced entry to runner-up admission and adds two walks (find the minimum,
// then the new threshold). A dequeue from a nonempty good tier adds one walk. When good
// and runner-up tiers are both empty a dequeue first refills from the overflow memory:
// read, use and next states per overflow entry, plus a walk for each entry that arrives
// once the good tier is full, plus one walk for the new threshold.
module tiered_topk_priority_queue import tq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tq_in_if.sink      in_if,
  tq_out_if.source   out_if,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data
);
  state_t state_r, state_nxt;
  purp_t  purp_r, purp_nxt;
  logic [4:0] gsize_r;
  logic [3:0] rsize_r;
  logic [GW:0] gc_r, gc_nxt, gs_eff;
  logic [RW:0] rc_r, rc_nxt, rs_eff;
  logic [OW:0] oc_r, oc_nxt, ri_r, ri_nxt;
  logic signed [31:0] thr_r, thr_nxt;
  logic fill_r, fill_nxt, lost_r, lost_nxt, thr_after_r, thr_after_nxt;
  entry_t req_r, req_nxt, ent_r, ent_nxt, best_r, best_nxt, bf, cand, mem_q;
  logic [GW-1:0] sj_r, sj_nxt, bi_r, bi_nxt, bi_f;
  logic take, scan_last, in_ready;
  logic out_valid_r, out_valid_nxt, found_r, found_nxt, drop_r, drop_nxt;
  entry_t res_r, res_nxt;
  logic [8:0] total_r, total_nxt;
  good_ctl_t gctl;
  run_ctl_t  rctl;
  logic ovf_we;
  entry_t ovf_wd;
  entry_t ovf_mem [OVF_DEPTH];
  entry_t good_e [GOOD_DEPTH];
  entry_t run_e [RUN_DEPTH];
  logic   run_lt [RUN_DEPTH];
  entry_t run_top;

  assign gs_eff = (gsize_r == '0) ? (GW+1)'(1) :
                  (gsize_r > 5'(GOOD_DEPTH)) ? (GW+1)'(GOOD_DEPTH) : (GW+1)'(gsize_r);
  assign rs_eff = (rsize_r > 4'(RUN_DEPTH)) ? (RW+1)'(RUN_DEPTH) : (RW+1)'(rsize_r);

  for (genvar i = 0; i < GOOD_DEPTH; i++) begin : g_good
    tq_good_cell u_cell (
      .clk(clk), .ctl(gctl), .pos(GW'(i)),
      .next_i((i == GOOD_DEPTH-1) ? good_e[i] : good_e[(i+1) % GOOD_DEPTH]),
      .ent_o(good_e[i])
    );
  end

  for (genvar i = 0; i < RUN_DEPTH; i++) begin : g_run
    tq_run_cell u_cell (
      .clk(clk), .ctl(rctl), .pos(RW'(i)),
      .prev_i((i == 0) ? run_e[i] : run_e[(i+RUN_DEPTH-1) % RUN_DEPTH]),
      .prev_lt_i((i == 0) ? 1'b0 : run_lt[(i+RUN_DEPTH-1) % RUN_DEPTH]),
      .next_i((i == RUN_DEPTH-1) ? run_e[i] : run_e[(i+1) % RUN_DEPTH]),
      .ent_o(run_e[i]), .lt_o(run_lt[i])
    );
  end

  assign run_top = run_e[RW'(rc_r - 1'b1)];

  // walk of the good tier, one slot a beat
  always_comb begin
    cand      = good_e[sj_r];
    if (purp_r == P_MAX) take = (sj_r == '0) || (cand.score > best_r.score);
    else take = (sj_r == '0) || (cand.score <= best_r.score);
    bf        = take ? cand : best_r;
    bi_f      = take ? sj_r : bi_r;
    scan_last = ({1'b0, sj_r} == gc_r - 1'b1);
  end

  assign in_ready    = (state_r == S_IDLE) && (!out_valid_r || out_if.ready);
  assign in_if.ready = in_ready;

  always_comb begin
    state_nxt = state_r; purp_nxt = purp_r;
    gc_nxt = gc_r; rc_nxt = rc_r; oc_nxt = oc_r; ri_nxt = ri_r;
    thr_nxt = thr_r; fill_nxt = fill_r; lost_nxt = lost_r; thr_after_nxt = thr_after_r;
    req_nxt = req_r; ent_nxt = ent_r; best_nxt = best_r; bi_nxt = bi_r; sj_nxt = sj_r;
    found_nxt = found_r; res_nxt = res_r; drop_nxt = drop_r; total_nxt = total_r;
    out_valid_nxt = out_valid_r;
    gctl = '{cmd: G_HOLD, idx: '0, cnt: gc_r, ent: req_r};
    rctl = '{cmd: R_HOLD, cnt: rc_r, ent: ent_r};
    ovf_we = 1'b0; ovf_wd = ent_r;

    if (out_valid_r && out_if.ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_if.valid && in_ready) begin
          req_nxt = '{key: in_if.entry_key, tag: in_if.entry_tag, score: in_if.entry_score};
          found_nxt = 1'b0; res_nxt = '0; lost_nxt = 1'b0; thr_after_nxt = 1'b0;
          state_nxt = (in_if.kind == KIND_ENQ) ? S_ENQ : S_DEQ;
        end
      end
      S_ENQ: begin
        if (gc_r < gs_eff) begin
          gctl.cmd = G_APPEND;
          gc_nxt = gc_r + 1'b1;
          if (fill_r && (gc_r == '0 || req_r.score < thr_r)) thr_nxt = req_r.score;
          if (gc_r + 1'b1 == gs_eff) begin
            fill_nxt = 1'b0; purp_nxt = P_THR; sj_nxt = '0; state_nxt = S_SCAN;
          end else state_nxt = S_DONE;
        end else if (req_r.score > thr_r) begin
          purp_nxt = P_EVICT; sj_nxt = '0; state_nxt = S_SCAN;
        end else begin
          ent_nxt = req_r; state_nxt = S_RADMIT;
        end
      end
      S_DEQ: begin
        if (gc_r == '0 && rc_r == '0 && oc_r != '0) begin
          gc_nxt = '0; ri_nxt = '0; state_nxt = S_REF_RD;
        end else if (gc_r != '0) begin
          purp_nxt = P_MAX; sj_nxt = '0; state_nxt = S_SCAN;
        end else state_nxt = S_DONE;
      end
      S_SCAN: begin
        best_nxt = bf; bi_nxt = bi_f; sj_nxt = sj_r + 1'b1;
        if (scan_last) begin
          sj_nxt = '0;
          case (purp_r)
            P_THR: begin
              thr_nxt = bf.score;
              state_nxt = S_DONE;
            end
            P_EVICT: begin
              gctl = '{cmd: G_REMAPP, idx: bi_f, cnt: gc_r, ent: req_r};
              ent_nxt = bf; thr_after_nxt = 1'b1; state_nxt = S_RADMIT;
            end
            P_MAX: begin
              found_nxt = 1'b1; res_nxt = bf;
              if (rc_r != '0) begin
                gctl = '{cmd: G_REMAPP, idx: bi_f, cnt: gc_r, ent: run_top};
                rc_nxt = rc_r - 1'b1;
              end else begin
                gctl = '{cmd: G_REMOVE, idx: bi_f, cnt: gc_r, ent: req_r};
                gc_nxt = gc_r - 1'b1;
              end
              state_nxt = S_DONE;
            end
            P_REFMIN: begin
              if (ent_r.score > bf.score)
                gctl = '{cmd: G_REMAPP, idx: bi_f, cnt: gc_r, ent: ent_r};
              state_nxt = S_REF_NEXT;
            end
            P_REFTHR: begin
              thr_nxt = bf.score; purp_nxt = P_MAX;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_RADMIT: begin
        state_nxt = thr_after_r ? S_SCAN : S_DONE;
        purp_nxt = P_THR; sj_nxt = '0;
        if (rs_eff == '0) begin
          ovf_we = 1'b1;
        end else if (rc_r < rs_eff) begin
          rctl.cmd = R_INSERT; rc_nxt = rc_r + 1'b1;
        end else if (rc_r != '0 && ent_r.score > run_e[0].score) begin
          ovf_we = 1'b1; ovf_wd = run_e[0];
          rctl.cmd = R_SHIFT; rc_nxt = rc_r - 1'b1;
          state_nxt = S_RINS;
        end else begin
          ovf_we = 1'b1;
        end
        if (ovf_we) begin
          if (oc_r < (OW+1)'(OVF_DEPTH)) oc_nxt = oc_r + 1'b1;
          else lost_nxt = 1'b1;
        end
      end
      S_RINS: begin
        rctl.cmd = R_INSERT; rc_nxt = rc_r + 1'b1;
        purp_nxt = P_THR; sj_nxt = '0;
        state_nxt = thr_after_r ? S_SCAN : S_DONE;
      end
      S_REF_RD: state_nxt = S_REF_USE;
      S_REF_USE: begin
        ent_nxt = mem_q;
        if (gc_r < gs_eff) begin
          gctl = '{cmd: G_APPEND, idx: '0, cnt: gc_r, ent: mem_q};
          gc_nxt = gc_r + 1'b1;
          state_nxt = S_REF_NEXT;
        end else begin
          purp_nxt = P_REFMIN; sj_nxt = '0; state_nxt = S_SCAN;
        end
      end
      S_REF_NEXT: begin
        if (ri_r + 1'b1 == oc_r) begin
          oc_nxt = '0; rc_nxt = '0;
          purp_nxt = P_REFTHR; sj_nxt = '0; state_nxt = S_SCAN;
        end else begin
          ri_nxt = ri_r + 1'b1; state_nxt = S_REF_RD;
        end
      end
      S_DONE: begin
        drop_nxt = lost_r;
        total_nxt = 9'(gc_r) + 9'(rc_r) + 9'(oc_r);
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; gc_r <= '0; rc_r <= '0; oc_r <= '0;
      thr_r <= '0; fill_r <= 1'b1; out_valid_r <= 1'b0;
      gsize_r <= 5'(GOOD_DEPTH); rsize_r <= 4'(RUN_DEPTH);
    end else begin
      state_r <= state_nxt; gc_r <= gc_nxt; rc_r <= rc_nxt; oc_r <= oc_nxt;
      thr_r <= thr_nxt; fill_r <= fill_nxt; out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_GOOD_SIZE:   gsize_r <= cfg_data;
          CFG_RUNNER_SIZE: rsize_r <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    purp_r <= purp_nxt; ri_r <= ri_nxt; lost_r <= lost_nxt; thr_after_r <= thr_after_nxt;
    req_r <= req_nxt; ent_r <= ent_nxt; best_r <= best_nxt; bi_r <= bi_nxt; sj_r <= sj_nxt;
    found_r <= found_nxt; res_r <= res_nxt; drop_r <= drop_nxt; total_r <= total_nxt;
  end

  // overflow tier storage
  always_ff @(posedge clk) begin
    if (ovf_we && oc_r < (OW+1)'(OVF_DEPTH)) ovf_mem[oc_r[OW-1:0]] <= ovf_wd;
    mem_q <= ovf_mem[ri_r[OW-1:0]];
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.found       = found_r;
  assign out_if.out_key     = res_r.key;
  assign out_if.out_tag     = res_r.tag;
  assign out_if.out_score   = res_r.score;
  assign out_if.dropped     = drop_r;
  assign out_if.total_count = total_r;
endmodule

>>> bench/tiered_topk_priority_queue_tb.sv
// Self-checking bench for tiered_topk_priority_queue: table-driven directed beats,
// then random enqueue/dequeue traffic under several tier sizes, scored by a local model.
// Depends on tq_pkg, tq_in_if, tq_out_if and the block itself.
`timescale 1ns / 100ps

module tiered_topk_priority_queue_tb;
  import tq_pkg::*;

  typedef struct {
    bit                 found;
    logic [31:0]        key;
    logic [31:0]        tag;
    logic signed [31:0] score;
    bit                 dropped;
    logic [8:0]         total;
  } deq_res_t;

  typedef struct {
    logic               kind;
    logic [31:0]        key;
    logic [31:0]        tag;
    logic signed [31:0] score;
    bit                 typed;
    deq_res_t           res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [4:0] cfg_data;

  tq_in_if  in_if();
  tq_out_if out_if();

  tiered_topk_priority_queue uut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // queue model state
  entry_t             good_q[GOOD_DEPTH];
  int                 good_n;
  entry_t             run_q[RUN_DEPTH];
  int                 run_n;
  entry_t             ovf_q[OVF_DEPTH];
  int                 ovf_n;
  logic signed [31:0] thr;
  bit                 filling;
  int                 good_cap_raw;
  int                 run_cap_raw;

  deq_res_t pending_results[$];
  int       errors;
  int       mismatches;
  int       beats_in;
  int       beats_out;
  int       n_found;
  int       n_dropped;
  int       n_refill;
  int       cycles;
  int       tx_idle_pct;
  int       rx_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int good_cap();
    if (good_cap_raw == 0) return 1;
    if (good_cap_raw > GOOD_DEPTH) return GOOD_DEPTH;
    return good_cap_raw;
  endfunction

  function automatic int run_cap();
    return (run_cap_raw > RUN_DEPTH) ? RUN_DEPTH : run_cap_raw;
  endfunction

  // newest of equal minima
  function automatic int good_min_idx();
    int b;
    b = 0;
    for (int i = 1; i < good_n; i++)
      if (good_q[i].score <= good_q[b].score) b = i;
    return b;
  endfunction

  // oldest of equal maxima
  function automatic int good_max_idx();
    int b;
    b = 0;
    for (int i = 1; i < good_n; i++)
      if (good_q[i].score > good_q[b].score) b = i;
    return b;
  endfunction

  function automatic void good_del(int idx);
    for (int i = idx; i + 1 < good_n; i++) good_q[i] = good_q[i + 1];
    if (good_n > 0) good_n--;
  endfunction

  function automatic void good_add(entry_t e);
    if (good_n >= GOOD_DEPTH) return;
    good_q[good_n] = e;
    good_n++;
  endfunction

  function automatic bit ovf_add(entry_t e);
    if (ovf_n >= OVF_DEPTH) return 1'b1;
    ovf_q[ovf_n] = e;
    ovf_n++;
    return 1'b0;
  endfunction

  function automatic void run_ins(entry_t e);
    int p;
    if (run_n >= RUN_DEPTH) return;
    p = 0;
    while (p < run_n && run_q[p].score < e.score) p++;
    for (int i = run_n; i > p; i--) run_q[i] = run_q[i - 1];
    run_q[p] = e;
    run_n++;
  endfunction

  function automatic bit run_admit(entry_t e);
    bit lost;
    if (run_cap() == 0) return ovf_add(e);
    if (run_n < run_cap()) begin
      run_ins(e);
      return 1'b0;
    end
    if (run_n > 0 && e.score > run_q[0].score) begin
      lost = ovf_add(run_q[0]);
      for (int i = 0; i + 1 < run_n; i++) run_q[i] = run_q[i + 1];
      run_n--;
      run_ins(e);
      return lost;
    end
    return ovf_add(e);
  endfunction

  function automatic void refill_good();
    int idx;
    if (ovf_n == 0) return;
    n_refill++;
    good_n = 0;
    for (int i = 0; i < ovf_n; i++) begin
      if (good_n < good_cap()) good_add(ovf_q[i]);
      else begin
        idx = good_min_idx();
        if (ovf_q[i].score > good_q[idx].score) begin
          good_del(idx);
          good_add(ovf_q[i]);
        end
      end
    end
    thr = (good_n > 0) ? good_q[good_min_idx()].score : '0;
    ovf_n = 0;
    run_n = 0;
  endfunction

  function automatic deq_res_t rank_step(logic kind, logic [31:0] k, logic [31:0] t,
                                         logic signed [31:0] s);
    deq_res_t r;
    entry_t   e;
    entry_t   ev;
    int       idx;
    r = '{default: '0};
    e.key = k;
    e.tag = t;
    e.score = s;
    if (kind == KIND_ENQ) begin
      if (good_n < good_cap()) begin
        good_add(e);
        if (filling && (good_n == 1 || s < thr)) thr = s;
        if (good_n == good_cap()) begin
          filling = 1'b0;
          thr = good_q[good_min_idx()].score;
        end
      end else if (s > thr) begin
        idx = good_min_idx();
        ev = good_q[idx];
        good_del(idx);
        good_add(e);
        r.dropped = run_admit(ev);
        thr = good_q[good_min_idx()].score;
      end else begin
        r.dropped = run_admit(e);
      end
    end else begin
      if (good_n == 0 && run_n == 0) refill_good();
      if (good_n > 0) begin
        idx = good_max_idx();
        r.found = 1'b1;
        r.key = good_q[idx].key;
        r.tag = good_q[idx].tag;
        r.score = good_q[idx].score;
        good_del(idx);
        if (run_n > 0) begin
          run_n--;
          good_add(run_q[run_n]);
        end
      end
    end
    r.total = 9'(good_n + run_n + ovf_n);
    return r;
  endfunction

  // drive one request beat; valid stays high when the next beat follows at once
  task automatic send_beat(logic kind, logic [31:0] k, logic [31:0] t,
                           logic signed [31:0] s, bit typed, deq_res_t want);
    deq_res_t got;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.kind <= kind;
    in_if.entry_key <= k;
    in_if.entry_tag <= t;
    in_if.entry_score <= s;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    beats_in++;
    got = rank_step(kind, k, t, s);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [4:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_GOOD_SIZE) good_cap_raw = val;
    else run_cap_raw = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // result checker and receiver backpressure
  always @(posedge clk) begin
    deq_res_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("result beat with nothing expected");
      end else begin
        w = pending_results.pop_front();
        if (w.found) n_found++;
        if (w.dropped) n_dropped++;
        if (out_if.found !== w.found || out_if.out_key !== w.key ||
            out_if.out_tag !== w.tag || out_if.out_score !== w.score ||
            out_if.dropped !== w.dropped || out_if.total_count !== w.total) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp f=%0b k=%h t=%h s=%h d=%0b n=%0d",
                      " got f=%0b k=%h t=%h s=%h d=%0b n=%0d"},
                     w.found, w.key, w.tag, w.score, w.dropped, w.total,
                     out_if.found, out_if.out_key, out_if.out_tag, out_if.out_score,
                     out_if.dropped, out_if.total_count);
        end
      end
    end
    out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic stim_row_t row(logic kind, logic [31:0] k, logic [31:0] t,
                                    logic signed [31:0] s, bit typed, bit f,
                                    logic [31:0] rk, logic [31:0] rt,
                                    logic signed [31:0] rs, int n);
    stim_row_t r;
    r.kind = kind;
    r.key = k;
    r.tag = t;
    r.score = s;
    r.typed = typed;
    r.res = '{found: f, key: rk, tag: rt, score: rs, dropped: 1'b0, total: 9'(n)};
    return r;
  endfunction

  initial begin
    stim_row_t          plan[$];
    int                 ph_good[5];
    int                 ph_run[5];
    int                 ph_len[5];
    int                 ph_enq[5];
    int                 done;
    int                 burst;
    logic               kind;
    logic signed [31:0] sc;
    deq_res_t           none;

    none = '{default: '0};
    ph_good = '{1, 31, 0, 5, 16};
    ph_run  = '{0, 15, 3, 8, 1};
    ph_len  = '{260, 130, 100, 130, 80};
    ph_enq  = '{92, 40, 55, 50, 35};
    errors = 0; mismatches = 0; beats_in = 0; beats_out = 0;
    n_found = 0; n_dropped = 0; n_refill = 0; cycles = 0;
    tx_idle_pct = 26; rx_idle_pct = 84;
    good_n = 0; run_n = 0; ovf_n = 0; thr = '0; filling = 1'b1;
    good_cap_raw = 16; run_cap_raw = 8;

    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = CFG_GOOD_SIZE; cfg_data = '0;
    in_if.valid = 1'b0; in_if.kind = KIND_ENQ;
    in_if.entry_key = '0; in_if.entry_tag = '0; in_if.entry_score = '0;
    out_if.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty queue, extremes, tie order; typed rows read straight off the rules
    plan.push_back(row(~KIND_ENQ, 32'hdeadbeef, 32'h1, 32'sh5, 1, 0, 0, 0, 0, 0));
    plan.push_back(row(KIND_ENQ, 32'hffffffff, 32'h0, 32'sh7fffffff, 1, 0, 0, 0, 0, 1));
    plan.push_back(row(KIND_ENQ, 32'h0, 32'hffffffff, 32'sh80000000, 1, 0, 0, 0, 0, 2));
    plan.push_back(row(~KIND_ENQ, 0, 0, 0, 1, 1, 32'hffffffff, 32'h0, 32'sh7fffffff, 1));
    plan.push_back(row(~KIND_ENQ, 0, 0, 0, 1, 1, 32'h0, 32'hffffffff, 32'sh80000000, 0));
    plan.push_back(row(KIND_ENQ, 32'h1, 32'ha, 32'sh0, 1, 0, 0, 0, 0, 1));
    plan.push_back(row(KIND_ENQ, 32'h2, 32'hb, 32'sh0, 1, 0, 0, 0, 0, 2));
    plan.push_back(row(~KIND_ENQ, 0, 0, 0, 1, 1, 32'h1, 32'ha, 32'sh0, 1));
    plan.push_back(row(~KIND_ENQ, 0, 0, 0, 1, 1, 32'h2, 32'hb, 32'sh0, 0));
    // fill past the good tier so eviction and runner-up insert show up
    for (int i = 0; i < 20; i++)
      plan.push_back(row(KIND_ENQ, 32'h100 + i, 32'h200 + i, 32'(i * 3 % 7 - 3),
                         0, 0, 0, 0, 0, 0));
    plan.push_back(row(~KIND_ENQ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    foreach (plan[i])
      send_beat(plan[i].kind, plan[i].key, plan[i].tag, plan[i].score,
                plan[i].typed, plan[i].typed ? plan[i].res : none);
    for (int i = 0; i < 40; i++) send_beat(~KIND_ENQ, 0, 0, 0, 0, none);

    done = 0;
    for (int p = 0; p < 5; p++) begin
      settle();
      write_reg(CFG_GOOD_SIZE, 5'(ph_good[p]));
      write_reg(CFG_RUNNER_SIZE, 5'(ph_run[p]));
      burst = 0;
      for (int i = 0; i < ph_len[p]; i++) begin
        if (done < 270) begin
          tx_idle_pct = 26; rx_idle_pct = 84;
        end else if (done < 540) begin
          tx_idle_pct = 84; rx_idle_pct = 26;
        end else begin
          tx_idle_pct = 0; rx_idle_pct = 0;
        end
        // runs of one operation so tiers can fill up and drain
        if (burst == 0) begin
          kind = ($urandom_range(99) < ph_enq[p]) ? KIND_ENQ : ~KIND_ENQ;
          burst = $urandom_range(1, 12);
        end
        burst--;
        if ($urandom_range(1)) sc = $urandom;
        else sc = 32'($urandom_range(8)) - 32'sd4;
        send_beat(kind, $urandom, $urandom, sc, 0, none);
        done++;
      end
    end
    // a final run of dequeues toward draining the tiers, touching the refill path on the way
    tx_idle_pct = 0;
    for (int i = 0; i < 30; i++) send_beat(~KIND_ENQ, $urandom, $urandom, $urandom, 0, none);
    settle();

    if (pending_results.size() != 0) errors++;
    $display("covered %0d requests, %0d results: %0d dequeue hits, %0d drops, %0d refills",
             beats_in, beats_out, n_found, n_dropped, n_refill);
    $display("tier sizes walked from 1/0 through out-of-range 31/15 and 0/3; %0d mismatches",
             mismatches);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> tiered_topk_priority_queue.f
src/tq_pkg.sv
src/tq_in_if.sv
src/tq_out_if.sv
src/tq_good_cell.sv
src/tq_run_cell.sv
src/tiered_topk_priority_queue.sv
bench/tiered_topk_priority_queue_tb.sv
